### sv/ibblit_pkg.sv
// Shared types and constants for the indexed bitmap blitter with chroma key.
// No dependencies; used by the interfaces, the register block and the top level.
`default_nettype none

package ibblit_pkg;

  localparam int MAX_DIM_DEF = 1024;

  // Register field widths.
  localparam int POS_W   = 12;
  localparam int DIM_W   = 11;
  localparam int SKIP_W  = 10;
  localparam int KEY_W   = 9;
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 16;
  localparam int ADDR_W  = 20;

  // Configuration port.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_SRC_WIDTH     = 3'd2,
    REG_SRC_HEIGHT    = 3'd3,
    REG_SRC_ROW_SKIP  = 3'd4,
    REG_KEY_IDX       = 3'd5,
    REG_CANVAS_WIDTH  = 3'd6,
    REG_CANVAS_HEIGHT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [POS_W-1:0]  dest_x;
    logic [POS_W-1:0]  dest_y;
    logic [DIM_W-1:0]  src_width;
    logic [DIM_W-1:0]  src_height;
    logic [SKIP_W-1:0] src_row_skip;
    logic [KEY_W-1:0]  key_idx;
    logic [DIM_W-1:0]  canvas_width;
    logic [DIM_W-1:0]  canvas_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    dest_x:        12'd0,
    dest_y:        12'd0,
    src_width:     11'd1,
    src_height:    11'd1,
    src_row_skip:  10'd0,
    key_idx:       9'd256,
    canvas_width:  11'd1024,
    canvas_height: 11'd1024
  };

endpackage

`default_nettype wire

### sv/ibblit_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on ibblit_pkg for field widths.
`default_nettype none

interface ibblit_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [ibblit_pkg::IDX_W-1:0]      pixel_index;
  logic [ibblit_pkg::IDX_W-1:0]      palette_addr;
  logic [ibblit_pkg::COLOR_W-1:0]    palette_color;

  modport source (output valid, req_type, pixel_index, palette_addr, palette_color,
                  input ready);
  modport sink   (input valid, req_type, pixel_index, palette_addr, palette_color,
                  output ready);
endinterface

interface ibblit_res_if;
  logic                              valid;
  logic                              ready;
  logic                              write_enable;
  logic [ibblit_pkg::ADDR_W-1:0]     fb_address;
  logic [ibblit_pkg::COLOR_W-1:0]    pixel_color;
  logic                              blit_done;

  modport source (output valid, write_enable, fb_address, pixel_color, blit_done,
                  input ready);
  modport sink   (input valid, write_enable, fb_address, pixel_color, blit_done,
                  output ready);
endinterface

`default_nettype wire

### sv/ibblit_regs.sv
// APB-style configuration registers of the blitter.
// Depends on ibblit_pkg for the register map and the cfg_t bundle.
`default_nettype none

module ibblit_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ibblit_pkg::PADDR_W-1:0] paddr,
  input  logic [ibblit_pkg::PDATA_W-1:0] pwdata,
  output logic [ibblit_pkg::PDATA_W-1:0] prdata,
  output logic                           pready,
  output ibblit_pkg::cfg_t               cfg_o
);

  ibblit_pkg::cfg_t      cfg_q, cfg_d;
  ibblit_pkg::reg_idx_e  reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = ibblit_pkg::reg_idx_e'(paddr[ibblit_pkg::PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        ibblit_pkg::REG_DEST_X:        cfg_d.dest_x        = pwdata[ibblit_pkg::POS_W-1:0];
        ibblit_pkg::REG_DEST_Y:        cfg_d.dest_y        = pwdata[ibblit_pkg::POS_W-1:0];
        ibblit_pkg::REG_SRC_WIDTH:     cfg_d.src_width     = pwdata[ibblit_pkg::DIM_W-1:0];
        ibblit_pkg::REG_SRC_HEIGHT:    cfg_d.src_height    = pwdata[ibblit_pkg::DIM_W-1:0];
        ibblit_pkg::REG_SRC_ROW_SKIP:  cfg_d.src_row_skip  = pwdata[ibblit_pkg::SKIP_W-1:0];
        ibblit_pkg::REG_KEY_IDX:       cfg_d.key_idx       = pwdata[ibblit_pkg::KEY_W-1:0];
        ibblit_pkg::REG_CANVAS_WIDTH:  cfg_d.canvas_width  = pwdata[ibblit_pkg::DIM_W-1:0];
        ibblit_pkg::REG_CANVAS_HEIGHT: cfg_d.canvas_height = pwdata[ibblit_pkg::DIM_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ibblit_pkg::REG_DEST_X:        prdata = ibblit_pkg::PDATA_W'(cfg_q.dest_x);
      ibblit_pkg::REG_DEST_Y:        prdata = ibblit_pkg::PDATA_W'(cfg_q.dest_y);
      ibblit_pkg::REG_SRC_WIDTH:     prdata = ibblit_pkg::PDATA_W'(cfg_q.src_width);
      ibblit_pkg::REG_SRC_HEIGHT:    prdata = ibblit_pkg::PDATA_W'(cfg_q.src_height);
      ibblit_pkg::REG_SRC_ROW_SKIP:  prdata = ibblit_pkg::PDATA_W'(cfg_q.src_row_skip);
      ibblit_pkg::REG_KEY_IDX:       prdata = ibblit_pkg::PDATA_W'(cfg_q.key_idx);
      ibblit_pkg::REG_CANVAS_WIDTH:  prdata = ibblit_pkg::PDATA_W'(cfg_q.canvas_width);
      ibblit_pkg::REG_CANVAS_HEIGHT: prdata = ibblit_pkg::PDATA_W'(cfg_q.canvas_height);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ibblit_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sv/ibblit_palette.sv
// 256-entry RGB565 palette memory: one write port, one read port with registered data.
// Depends on ibblit_pkg for widths.
`default_nettype none

module ibblit_palette (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [ibblit_pkg::IDX_W-1:0]   waddr_i,
  input  logic [ibblit_pkg::COLOR_W-1:0] wdata_i,
  input  logic                           re_i,
  input  logic [ibblit_pkg::IDX_W-1:0]   raddr_i,
  output logic [ibblit_pkg::COLOR_W-1:0] rdata_o
);

  localparam int Depth = 1 << ibblit_pkg::IDX_W;

  logic [ibblit_pkg::COLOR_W-1:0] mem_q [Depth];
  logic [ibblit_pkg::COLOR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/indexed_bitmap_blit_chroma_key.sv
// Indexed bitmap blitter with chroma key: top level.
// An accepted item is held in the input stage and then in the result register; the palette
// read and the placement logic sit between the input stage and the result register.
// Throughput: one item per cycle; input is held off only while a result waits with the input
// stage full. Reset clears the counters, the pipeline valids and the registers to their
// defaults; the palette holds no defined contents until written.
`default_nettype none

module indexed_bitmap_blit_chroma_key #(
  parameter int MAX_DIM = ibblit_pkg::MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ibblit_req_if.sink                     req_i,
  ibblit_res_if.source                   res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ibblit_pkg::PADDR_W-1:0] paddr,
  input  logic [ibblit_pkg::PDATA_W-1:0] pwdata,
  output logic [ibblit_pkg::PDATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int DW      = ibblit_pkg::DIM_W;
  localparam int COL_W   = $clog2(MAX_DIM + 1023);
  localparam int ROW_W   = $clog2(MAX_DIM);
  localparam int LEN_W   = DW + 1;
  localparam int CCMP_W  = ((COL_W > LEN_W) ? COL_W : LEN_W) + 1;
  localparam int RCMP_W  = ((ROW_W > DW) ? ROW_W : DW) + 1;
  localparam int PX_W    = ((COL_W > ibblit_pkg::POS_W) ? COL_W : ibblit_pkg::POS_W) + 1;
  localparam int PY_W    = ((ROW_W > ibblit_pkg::POS_W) ? ROW_W : ibblit_pkg::POS_W) + 1;
  localparam int PROD_W  = PY_W - 1 + DW;

  ibblit_pkg::cfg_t cfg;

  ibblit_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake and pipeline control.
  logic in_fire, advance;
  logic s1_valid_q, out_valid_q;

  assign advance     = !out_valid_q || res_o.ready;
  assign req_i.ready = !s1_valid_q || advance;
  assign in_fire     = req_i.valid && req_i.ready;

  // Clamped geometry.
  logic [DW-1:0]    src_w, src_h, canvas_w, canvas_h;
  logic [LEN_W-1:0] row_len;

  always_comb begin
    if (cfg.src_width == '0) begin
      src_w = DW'(1);
    end else if (32'(cfg.src_width) > 32'(MAX_DIM)) begin
      src_w = DW'(MAX_DIM);
    end else begin
      src_w = cfg.src_width;
    end
    if (cfg.src_height == '0) begin
      src_h = DW'(1);
    end else if (32'(cfg.src_height) > 32'(MAX_DIM)) begin
      src_h = DW'(MAX_DIM);
    end else begin
      src_h = cfg.src_height;
    end
    canvas_w = (32'(cfg.canvas_width) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : cfg.canvas_width;
    canvas_h = (32'(cfg.canvas_height) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : cfg.canvas_height;
  end

  assign row_len = LEN_W'(src_w) + LEN_W'(cfg.src_row_skip);

  // Source position counters; a counter found past its limit is treated as the last one.
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             last_col, last_row, pix_fire;

  assign pix_fire = in_fire && !req_i.req_type;
  assign last_col = (CCMP_W'(col_q) + CCMP_W'(1)) >= CCMP_W'(row_len);
  assign last_row = (RCMP_W'(row_q) + RCMP_W'(1)) >= RCMP_W'(src_h);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_fire) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Palette: written by palette items, read for every accepted item.
  logic [ibblit_pkg::COLOR_W-1:0] pal_rdata;

  ibblit_palette u_palette (
    .clk_i   (clk_i),
    .we_i    (in_fire && req_i.req_type),
    .waddr_i (req_i.palette_addr),
    .wdata_i (req_i.palette_color),
    .re_i    (in_fire),
    .raddr_i (req_i.pixel_index),
    .rdata_o (pal_rdata)
  );

  // Input stage.
  logic                         s1_type_q, s1_done_q;
  logic [ibblit_pkg::IDX_W-1:0] s1_idx_q;
  logic [COL_W-1:0]             s1_col_q;
  logic [ROW_W-1:0]             s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_type_q <= req_i.req_type;
      s1_idx_q  <= req_i.pixel_index;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_done_q <= !req_i.req_type && last_col && last_row;
    end
  end

  // Placement, clipping, keying and address.
  logic signed [PX_W-1:0]        px;
  logic signed [PY_W-1:0]        py;
  logic [PX_W-2:0]               px_lo;
  logic [PY_W-2:0]               py_lo;
  logic                          visible, on_canvas, keyed, we;
  logic [PROD_W-1:0]             prod;
  logic [ibblit_pkg::ADDR_W-1:0] addr;

  assign px        = PX_W'($signed(cfg.dest_x)) + $signed(PX_W'(s1_col_q));
  assign py        = PY_W'($signed(cfg.dest_y)) + $signed(PY_W'(s1_row_q));
  assign px_lo     = px[PX_W-2:0];
  assign py_lo     = py[PY_W-2:0];
  assign visible   = (LEN_W'(s1_col_q) < LEN_W'(src_w)) && (CCMP_W'(s1_col_q) < CCMP_W'(src_w));
  assign on_canvas = !px[PX_W-1] && !py[PY_W-1] &&
                     (px_lo < (PX_W-1)'(canvas_w)) && (py_lo < (PY_W-1)'(canvas_h));
  assign keyed     = !cfg.key_idx[ibblit_pkg::KEY_W-1] &&
                     (s1_idx_q == cfg.key_idx[ibblit_pkg::IDX_W-1:0]);
  assign we        = !s1_type_q && visible && on_canvas && !keyed;
  assign prod      = PROD_W'(py_lo) * PROD_W'(canvas_w);
  assign addr      = ibblit_pkg::ADDR_W'(prod) + ibblit_pkg::ADDR_W'(px_lo);

  // Result register.
  logic                           out_we_q, out_done_q;
  logic [ibblit_pkg::ADDR_W-1:0]  out_addr_q;
  logic [ibblit_pkg::COLOR_W-1:0] out_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_we_q    <= we;
      out_addr_q  <= we ? addr : '0;
      out_color_q <= we ? pal_rdata : '0;
      out_done_q  <= s1_done_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.write_enable = out_we_q;
  assign res_o.fb_address   = out_addr_q;
  assign res_o.pixel_color  = out_color_q;
  assign res_o.blit_done    = out_done_q;

  // A stalled input stage keeps its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_idx_q) && $stable(s1_col_q))
    else $error("input stage lost its item while stalled");

  // A palette item never produces a framebuffer write or an end of stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_valid_q && s1_type_q |=> !res_o.write_enable && !res_o.blit_done)
    else $error("palette item produced a write or end of stream");

  // The end of stream always brings both counters back to the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_fire && last_col && last_row |=> col_q == '0 && row_q == '0)
    else $error("counters not cleared at end of stream");

  // Palette items leave the source position untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req_i.req_type |=> $stable(col_q) && $stable(row_q))
    else $error("palette item moved the source position");

endmodule

`default_nettype wire
